[hdl/rpa_pkg.sv]
// Shared constants, codes and types for the reference-counted page allocator.
// Used by refcounted_page_allocator; has no dependencies of its own.
package rpa_pkg;

  localparam int PAGE_COUNT = 32768;
  localparam int PAGE_BYTES = 4096;
  localparam int COUNT_BITS = 8;

  localparam int ADDR_W   = 32;
  localparam int PAGE_W   = 20;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int REF_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int PN_W    = ADDR_W - OFF_W;
  localparam int SLOT_W  = $clog2(PAGE_COUNT);
  localparam int DEPTH_W = $clog2(PAGE_COUNT + 1);
  // Wide enough for any page number and for first_page + PAGE_COUNT.
  localparam int CMP_W   = ((PN_W > PAGE_W) ? PN_W : PAGE_W) + 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [PAGE_W-1:0] FIRST_PAGE_RST = PAGE_W'(524544);
  localparam logic [PAGE_W-1:0] TOP_PAGE_RST   = PAGE_W'(557056);

  localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FREE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ADDREF = 3'd2;
  localparam logic [FUNC_W-1:0] FN_GET    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INIT   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_PAGE   = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_address;
    logic [REF_W-1:0]    ref_count;
    logic                page_released;
  } result_t;

endpackage

[hdl/rpa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; instantiated for the free stack and the count table.
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/refcounted_page_allocator.sv]
// Top level of the reference-counted page allocator: free-page stack and count table.
// Depends on rpa_pkg and rpa_ram.
//
//  channel   handshake            payload
//  command   start, busy          func, page_address
//  result    done (strobe)        status, result_address, ref_count, page_released
//  config    cfg_we               cfg_index, cfg_data
//
// Alloc, free, add reference, get and unknown codes read the stack and count RAMs
// in the accept cycle, then modify and, where needed, write back in S_EXEC; done is high the cycle after.
// Initialize sweeps every count slot, one RAM entry per cycle, with busy high
// until the last slot is written.
// After reset the block runs a clearing pass over all PAGE_COUNT = 32768 slots of the
// count RAM with busy high; configuration writes are taken during it.
// The receiver cannot stall: done is high for exactly one cycle with each result word.
module refcounted_page_allocator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [rpa_pkg::FUNC_W-1:0]         func,
  input  logic [rpa_pkg::ADDR_W-1:0]         page_address,
  output logic                               done,
  output logic [rpa_pkg::STATUS_W-1:0]       status,
  output logic [rpa_pkg::ADDR_W-1:0]         result_address,
  output logic [rpa_pkg::REF_W-1:0]          ref_count,
  output logic                               page_released,
  input  logic                               cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpa_pkg::PAGE_W-1:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  state_t state_q, state_next;

  logic [rpa_pkg::PAGE_W-1:0]     first_page_q, top_page_q;
  logic [rpa_pkg::DEPTH_W-1:0]    depth_q, depth_next;
  logic [rpa_pkg::SLOT_W-1:0]     idx_q, idx_next;
  logic                           sweep_op_q, sweep_op_next;
  logic                           done_q, done_next;
  rpa_pkg::result_t               res_q, res_next;

  logic [rpa_pkg::FUNC_W-1:0]     func_q;
  logic [rpa_pkg::PN_W-1:0]       page_q;
  logic [rpa_pkg::SLOT_W-1:0]     slot_q;
  logic                           valid_q;

  logic                           cnt_we, stk_we;
  logic [rpa_pkg::SLOT_W-1:0]     cnt_waddr, cnt_raddr, stk_waddr, stk_raddr;
  logic [rpa_pkg::COUNT_BITS-1:0] cnt_wdata, cnt_rd;
  logic [rpa_pkg::PAGE_W-1:0]     stk_wdata, stk_rd;

  logic                           accept;
  logic [rpa_pkg::PN_W-1:0]       in_pn;
  logic [rpa_pkg::CMP_W-1:0]      in_pn_ext, first_ext, win_end, sw_page;
  logic                           in_valid, sw_push;
  logic [rpa_pkg::COUNT_BITS-1:0] cnt_dec, cnt_inc;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // Window end is the smaller of top_page and first_page + PAGE_COUNT.
  assign first_ext = rpa_pkg::CMP_W'(first_page_q);
  always_comb begin
    win_end = first_ext + rpa_pkg::CMP_W'(rpa_pkg::PAGE_COUNT);
    if (rpa_pkg::CMP_W'(top_page_q) < win_end) begin
      win_end = rpa_pkg::CMP_W'(top_page_q);
    end
  end

  assign in_pn     = page_address[rpa_pkg::ADDR_W-1:rpa_pkg::OFF_W];
  assign in_pn_ext = rpa_pkg::CMP_W'(in_pn);
  assign in_valid  = (page_address[rpa_pkg::OFF_W-1:0] == '0) &&
                     (in_pn_ext >= first_ext) && (in_pn_ext < win_end);

  assign sw_page = first_ext + rpa_pkg::CMP_W'(idx_q);
  assign sw_push = sweep_op_q && (sw_page < win_end);

  assign cnt_dec = cnt_rd - 1'b1;
  assign cnt_inc = (cnt_rd < rpa_pkg::COUNT_MAX) ? cnt_rd + 1'b1 : cnt_rd;

  // The count read is launched from the command ports in the accept cycle; the stack read addresses entry depth - 1.
  assign cnt_raddr = rpa_pkg::SLOT_W'(in_pn);
  assign stk_raddr = rpa_pkg::SLOT_W'(depth_q - 1'b1);

  always_comb begin
    state_next    = state_q;
    depth_next    = depth_q;
    idx_next      = idx_q;
    sweep_op_next = sweep_op_q;
    done_next     = 1'b0;
    res_next      = res_q;
    cnt_we        = 1'b0;
    cnt_waddr     = slot_q;
    cnt_wdata     = '0;
    stk_we        = 1'b0;
    stk_waddr     = rpa_pkg::SLOT_W'(depth_q);
    stk_wdata     = rpa_pkg::PAGE_W'(page_q);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (func == rpa_pkg::FN_INIT) begin
            state_next    = S_SWEEP;
            sweep_op_next = 1'b1;
            idx_next      = '0;
            depth_next    = '0;
          end else begin
            state_next = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        res_next   = '0;
        case (func_q)
          rpa_pkg::FN_ALLOC: begin
            if (depth_q == '0) begin
              res_next.status = rpa_pkg::ST_OOM;
            end else begin
              depth_next              = depth_q - 1'b1;
              cnt_we                  = 1'b1;
              cnt_waddr               = rpa_pkg::SLOT_W'(stk_rd);
              cnt_wdata               = rpa_pkg::COUNT_BITS'(1);
              res_next.status         = rpa_pkg::ST_OK;
              res_next.result_address =
                rpa_pkg::ADDR_W'({stk_rd, {rpa_pkg::OFF_W{1'b0}}});
              res_next.ref_count      = rpa_pkg::REF_W'(1);
            end
          end
          rpa_pkg::FN_FREE: begin
            if (!valid_q) begin
              res_next.status = rpa_pkg::ST_BAD_ADDR;
            end else if (cnt_rd == '0) begin
              res_next.status = rpa_pkg::ST_UNDERFLOW;
            end else begin
              cnt_we          = 1'b1;
              cnt_wdata       = cnt_dec;
              res_next.status = rpa_pkg::ST_OK;
              if ((cnt_dec == '0) &&
                  (depth_q < rpa_pkg::DEPTH_W'(rpa_pkg::PAGE_COUNT))) begin
                stk_we                 = 1'b1;
                depth_next             = depth_q + 1'b1;
                res_next.page_released = 1'b1;
              end else begin
                res_next.ref_count = rpa_pkg::REF_W'(cnt_dec);
              end
            end
          end
          rpa_pkg::FN_ADDREF: begin
            if (!valid_q) begin
              res_next.status = rpa_pkg::ST_BAD_ADDR;
            end else begin
              cnt_we             = 1'b1;
              cnt_wdata          = cnt_inc;
              res_next.status    = rpa_pkg::ST_OK;
              res_next.ref_count = rpa_pkg::REF_W'(cnt_inc);
            end
          end
          rpa_pkg::FN_GET: begin
            if (!valid_q) begin
              res_next.status = rpa_pkg::ST_BAD_ADDR;
            end else begin
              res_next.status    = rpa_pkg::ST_OK;
              res_next.ref_count = rpa_pkg::REF_W'(cnt_rd);
            end
          end
          default: begin
            res_next.status = rpa_pkg::ST_INVALID;
          end
        endcase
      end

      S_SWEEP: begin
        // Each cycle clears one count slot and, for initialize, stacks one page if it lies below the window end.
        cnt_we    = 1'b1;
        cnt_waddr = idx_q;
        cnt_wdata = '0;
        stk_we    = sw_push;
        stk_waddr = idx_q;
        stk_wdata = rpa_pkg::PAGE_W'(sw_page);
        if (sw_push) begin
          depth_next = depth_q + 1'b1;
        end
        if (idx_q == rpa_pkg::SLOT_W'(rpa_pkg::PAGE_COUNT - 1)) begin
          state_next = S_IDLE;
          done_next  = sweep_op_q;
          res_next   = '0;
        end else begin
          idx_next = idx_q + 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q    <= S_SWEEP;
      depth_q    <= '0;
      idx_q      <= '0;
      sweep_op_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_next;
      depth_q    <= depth_next;
      idx_q      <= idx_next;
      sweep_op_q <= sweep_op_next;
      done_q     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_page_q <= rpa_pkg::FIRST_PAGE_RST;
      top_page_q   <= rpa_pkg::TOP_PAGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rpa_pkg::CFG_FIRST_PAGE: first_page_q <= cfg_data;
        rpa_pkg::CFG_TOP_PAGE:   top_page_q   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_next;
    if (accept) begin
      func_q  <= func;
      page_q  <= in_pn;
      slot_q  <= rpa_pkg::SLOT_W'(in_pn);
      valid_q <= in_valid;
    end
  end

  rpa_ram #(
    .WIDTH(rpa_pkg::COUNT_BITS),
    .DEPTH(rpa_pkg::PAGE_COUNT)
  ) u_counts (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rd)
  );

  rpa_ram #(
    .WIDTH(rpa_pkg::PAGE_W),
    .DEPTH(rpa_pkg::PAGE_COUNT)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rd)
  );

  assign done           = done_q;
  assign status         = res_q.status;
  assign result_address = res_q.result_address;
  assign ref_count      = res_q.ref_count;
  assign page_released  = res_q.page_released;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state_q == S_EXEC) || $past(state_q == S_SWEEP)))
    else $error("result word without a finished operation");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state_q == S_EXEC) |=> ((state_q == S_IDLE) && done))
    else $error("read-modify-write did not finish in one cycle");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth_q <= rpa_pkg::DEPTH_W'(rpa_pkg::PAGE_COUNT))
    else $error("free stack depth beyond capacity");

  a_release_word: assert property (@(posedge clk) disable iff (rst)
    (done && page_released) |-> ((status == rpa_pkg::ST_OK) && (ref_count == '0)))
    else $error("released page with a bad status or nonzero count");
`endif

endmodule
